/* hdl/tga_rle_image_decoder_defines.svh */
// assertion macros for the decoder top file
`ifndef TGA_RLE_IMAGE_DECODER_DEFINES_SVH
`define TGA_RLE_IMAGE_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// general form: explicit clock and active-low reset
`define TGA_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// usual form: the block clock and reset
`define TGA_ASSERT_CLK(name, prop, msg) \
  `TGA_ASSERT(name, clk_i, rst_ni, prop, msg)
`else
`define TGA_ASSERT(name, clk, rstn, prop, msg)
`define TGA_ASSERT_CLK(name, prop, msg)
`endif

`endif

/* hdl/tga_pkg.sv */
package tga_pkg;

  // header layout
  localparam int unsigned HDR_LEN  = 18;
  localparam int unsigned HDR_KEEP = 17;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HDR_OK = 2'd1;
  localparam logic [1:0] KIND_HDR_BAD = 2'd2;

  // header error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TYPE  = 2'd1;
  localparam logic [1:0] ERR_DEPTH = 2'd2;

  // command queue between front and back, depth a power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PACKET,
    PH_PIXEL
  } phase_e;

  // one command: a header report or a pixel repeated count times
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [5:0]  pix_bits;
    logic [31:0] pixel;
    logic [7:0]  count;
    logic        done;
  } cmd_t;

endpackage

/* hdl/tga_rle_image_decoder.sv */
// one file byte is taken per cycle while the command queue has room
// a byte that completes a header or a pixel queues a command; the back end registers it
// and then its words, one per cycle while the reader pops, so a run of n pixels gives
// ceil(n/2) words, and the four-entry command queue sets when input stalls
// reset clears parser phase, counters, queue pointers and output valid; no clearing pass
`include "tga_rle_image_decoder_defines.svh"

module tga_rle_image_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [5:0]  pixel_bits_o,
  output logic [31:0] pixel_first_o,
  output logic [31:0] pixel_second_o,
  output logic        second_valid_o,
  output logic        run_last_o,
  output logic        image_done_o
);

  tga_pkg::cmd_t q_in, q_out;
  logic q_push, q_full, q_pop, q_empty;

  assign full = q_full;

  // byte parser
  tga_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .cmd_full_i    (q_full),
    .cmd_push_o    (q_push),
    .cmd_o         (q_in)
  );

  // command queue
  tga_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // result expansion
  tga_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (q_out),
    .cmd_empty_i    (q_empty),
    .cmd_pop_o      (q_pop),
    .pop            (pop),
    .empty          (empty),
    .result_kind_o  (result_kind_o),
    .error_code_o   (error_code_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .pixel_bits_o   (pixel_bits_o),
    .pixel_first_o  (pixel_first_o),
    .pixel_second_o (pixel_second_o),
    .second_valid_o (second_valid_o),
    .run_last_o     (run_last_o),
    .image_done_o   (image_done_o)
  );

  // checks
  `TGA_ASSERT_CLK(a_no_push_full, q_push |-> !q_full, "command pushed into a full queue")
  `TGA_ASSERT_CLK(a_done_is_last, (!empty && image_done_o) |-> run_last_o, "image end not on last word")
  `TGA_ASSERT_CLK(a_pair_is_pixel, (!empty && second_valid_o) |-> (result_kind_o == tga_pkg::KIND_PIXEL), "pixel pair on header word")
  `TGA_ASSERT_CLK(a_hdr_single, (!empty && result_kind_o != tga_pkg::KIND_PIXEL) |-> (run_last_o && !image_done_o), "header word not single")

endmodule

/* hdl/tga_front.sv */
module tga_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    data_byte_i,
  input  logic          frame_start_i,
  input  logic          cmd_full_i,
  output logic          cmd_push_o,
  output tga_pkg::cmd_t cmd_o
);

  tga_pkg::phase_e phase_q, phase_d;
  logic [4:0]  hcnt_q, hcnt_d;
  logic [7:0]  hdr_q [tga_pkg::HDR_KEEP];
  logic [21:0] skip_q, skip_d;
  logic        rle_q, rle_d;
  logic [2:0]  bpp_q, bpp_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic        pkt_run_q, pkt_run_d;
  logic [1:0]  bip_q, bip_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] pix_left_q, pix_left_d;

  logic        accept;
  logic        hdr_we;

  // header fields read at fixed places
  logic [15:0] hdr_w, hdr_h, cmap_len;
  logic [7:0]  htype, hdepth;
  logic [1:0]  herr;
  logic [31:0] pix_total;
  logic [20:0] cmap_bytes;
  logic [21:0] skip_total;
  logic        skip_zero, new_rle;

  // pixel assembly and run clamp
  logic [31:0] acc_new;
  logic        is_run, run_done;
  logic [7:0]  run_n, px_n;

  assign accept = push_i & ~cmd_full_i;
  assign hdr_we = accept & (frame_start_i | ((phase_q == tga_pkg::PH_HEADER) &
                  (hcnt_q != 5'(tga_pkg::HDR_KEEP))));

  assign hdr_w    = {hdr_q[13], hdr_q[12]};
  assign hdr_h    = {hdr_q[15], hdr_q[14]};
  assign cmap_len = {hdr_q[6], hdr_q[5]};
  assign htype    = hdr_q[2];
  assign hdepth   = hdr_q[16];

  assign herr = (htype != tga_pkg::TYPE_RAW && htype != tga_pkg::TYPE_RLE) ? tga_pkg::ERR_TYPE :
                (hdepth != tga_pkg::DEPTH_24 && hdepth != tga_pkg::DEPTH_32) ?
                tga_pkg::ERR_DEPTH : tga_pkg::ERR_NONE;

  // image size and bytes to skip before the pixel data
  assign pix_total  = hdr_w * hdr_h;
  assign cmap_bytes = cmap_len * hdr_q[7][7:3];
  assign skip_total = {14'd0, hdr_q[0]} + {1'b0, cmap_bytes};
  assign skip_zero  = (hdr_q[0] == 8'd0) & ((cmap_len == 16'd0) | (hdr_q[7][7:3] == 5'd0));
  assign new_rle    = (htype == tga_pkg::TYPE_RLE);

  assign acc_new  = acc_q | ({24'd0, data_byte_i} << {bip_q, 3'b000});
  assign is_run   = rle_q & pkt_run_q;
  assign run_done = (pix_left_q <= {24'd0, pkt_left_q});
  assign run_n    = run_done ? pix_left_q[7:0] : pkt_left_q;
  assign px_n     = is_run ? run_n : 8'd1;

  // phase register and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tga_pkg::PH_IDLE;
      hcnt_q     <= 5'd0;
      skip_q     <= 22'd0;
      rle_q      <= 1'b0;
      bpp_q      <= 3'd0;
      pkt_left_q <= 8'd0;
      pkt_run_q  <= 1'b0;
      bip_q      <= 2'd0;
      acc_q      <= 32'd0;
      pix_left_q <= 32'd0;
    end else begin
      phase_q    <= phase_d;
      hcnt_q     <= hcnt_d;
      skip_q     <= skip_d;
      rle_q      <= rle_d;
      bpp_q      <= bpp_d;
      pkt_left_q <= pkt_left_d;
      pkt_run_q  <= pkt_run_d;
      bip_q      <= bip_d;
      acc_q      <= acc_d;
      pix_left_q <= pix_left_d;
    end
  end

  // header byte store, written at the header count
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[frame_start_i ? 5'd0 : hcnt_q] <= data_byte_i;
    end
  end

  // next state and command generation
  always_comb begin
    phase_d    = phase_q;
    hcnt_d     = hcnt_q;
    skip_d     = skip_q;
    rle_d      = rle_q;
    bpp_d      = bpp_q;
    pkt_left_d = pkt_left_q;
    pkt_run_d  = pkt_run_q;
    bip_d      = bip_q;
    acc_d      = acc_q;
    pix_left_d = pix_left_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.count = 8'd1;

    if (accept) begin
      if (frame_start_i) begin
        hcnt_d  = 5'd1;
        phase_d = tga_pkg::PH_HEADER;
      end else begin
        unique case (phase_q)
          tga_pkg::PH_HEADER: begin
            hcnt_d = hcnt_q + 5'd1;
            if (hcnt_q == 5'(tga_pkg::HDR_LEN - 1)) begin
              cmd_push_o       = 1'b1;
              cmd_o.kind       = (herr != tga_pkg::ERR_NONE) ? tga_pkg::KIND_HDR_BAD :
                                 tga_pkg::KIND_HDR_OK;
              cmd_o.err        = herr;
              cmd_o.img_width  = hdr_w;
              cmd_o.img_height = hdr_h;
              cmd_o.pix_bits   = hdepth[5:0];
              if (herr != tga_pkg::ERR_NONE) begin
                phase_d = tga_pkg::PH_IDLE;
              end else begin
                rle_d      = new_rle;
                bpp_d      = hdepth[5:3];
                pix_left_d = pix_total;
                skip_d     = skip_total;
                bip_d      = 2'd0;
                acc_d      = 32'd0;
                if (hdr_w == 16'd0 || hdr_h == 16'd0) begin
                  phase_d = tga_pkg::PH_IDLE;
                end else if (!skip_zero) begin
                  phase_d = tga_pkg::PH_SKIP;
                end else begin
                  phase_d = new_rle ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
                end
              end
            end
          end
          tga_pkg::PH_SKIP: begin
            skip_d = skip_q - 22'd1;
            if (skip_q == 22'd1) begin
              phase_d = rle_q ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
              bip_d   = 2'd0;
              acc_d   = 32'd0;
            end
          end
          tga_pkg::PH_PACKET: begin
            pkt_run_d  = data_byte_i[7];
            pkt_left_d = {1'b0, data_byte_i[6:0]} + 8'd1;
            phase_d    = tga_pkg::PH_PIXEL;
            bip_d      = 2'd0;
            acc_d      = 32'd0;
          end
          tga_pkg::PH_PIXEL: begin
            if (({1'b0, bip_q} + 3'd1) < bpp_q) begin
              bip_d = bip_q + 2'd1;
              acc_d = acc_new;
            end else begin
              bip_d        = 2'd0;
              acc_d        = 32'd0;
              cmd_push_o   = 1'b1;
              cmd_o.kind   = tga_pkg::KIND_PIXEL;
              cmd_o.pixel  = acc_new;
              cmd_o.count  = px_n;
              cmd_o.done   = is_run ? run_done : (pix_left_q == 32'd1);
              pix_left_d   = pix_left_q - {24'd0, px_n};
              if (is_run) begin
                pkt_left_d = 8'd0;
              end else if (rle_q && pkt_left_q != 8'd0) begin
                pkt_left_d = pkt_left_q - 8'd1;
              end
              if (cmd_o.done) begin
                phase_d = tga_pkg::PH_IDLE;
              end else if (rle_q && pkt_left_d == 8'd0) begin
                phase_d = tga_pkg::PH_PACKET;
              end
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

endmodule

/* hdl/tga_queue.sv */
module tga_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tga_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output tga_pkg::cmd_t data_o,
  output logic          empty_o
);

  tga_pkg::cmd_t mem_q [tga_pkg::QUEUE_DEPTH];
  logic [tga_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [tga_pkg::QPTR_W:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (tga_pkg::QPTR_W + 1)'(tga_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // command storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/tga_back.sv */
module tga_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tga_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  input  logic          pop,
  output logic          empty,
  output logic [1:0]    result_kind_o,
  output logic [1:0]    error_code_o,
  output logic [15:0]   image_width_o,
  output logic [15:0]   image_height_o,
  output logic [5:0]    pixel_bits_o,
  output logic [31:0]   pixel_first_o,
  output logic [31:0]   pixel_second_o,
  output logic          second_valid_o,
  output logic          run_last_o,
  output logic          image_done_o
);

  logic          act_v_q;
  tga_pkg::cmd_t act_q;
  logic [7:0]    rem_q;
  logic          out_v_q;

  logic two, last, out_load, act_free, pop_ok;

  // current result from the active command
  assign two      = (act_q.kind == tga_pkg::KIND_PIXEL) & (rem_q >= 8'd2);
  assign last     = (rem_q <= 8'd2);
  assign pop_ok   = pop & out_v_q;
  assign out_load = act_v_q & (~out_v_q | pop);
  assign act_free = ~act_v_q | (out_load & last);
  assign cmd_pop_o = act_free & ~cmd_empty_i;
  assign empty    = ~out_v_q;

  // active command and remaining pixel count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_v_q <= 1'b0;
    end else if (act_free) begin
      act_v_q <= ~cmd_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      act_q <= cmd_i;
      rem_q <= cmd_i.count;
    end else if (out_load) begin
      rem_q <= rem_q - (two ? 8'd2 : 8'd1);
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (pop_ok) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_kind_o  <= act_q.kind;
      error_code_o   <= act_q.err;
      image_width_o  <= act_q.img_width;
      image_height_o <= act_q.img_height;
      pixel_bits_o   <= act_q.pix_bits;
      pixel_first_o  <= act_q.pixel;
      pixel_second_o <= two ? act_q.pixel : 32'd0;
      second_valid_o <= two;
      run_last_o     <= last;
      image_done_o   <= last & act_q.done;
    end
  end

endmodule

/* verif/tga_rle_image_decoder_checker.sv */
`timescale 1ns / 100ps

module tga_rle_image_decoder_checker
  import tga_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  input  logic        pop_i,
  input  logic        empty_i,
  input  logic [1:0]  result_kind_i,
  input  logic [1:0]  error_code_i,
  input  logic [15:0] image_width_i,
  input  logic [15:0] image_height_i,
  input  logic [5:0]  pixel_bits_i,
  input  logic [31:0] pixel_first_i,
  input  logic [31:0] pixel_second_i,
  input  logic        second_valid_i,
  input  logic        run_last_i,
  input  logic        image_done_i,
  output int          fail_count_o,
  output int          pending_o
);

  // one decoded output word, in port order
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [15:0] width;
    logic [15:0] height;
    logic [5:0]  bits;
    logic [31:0] first;
    logic [31:0] second;
    logic        pair;
    logic        last;
    logic        done;
  } dec_word_t;

  // decoder state mirror
  phase_e      phase;
  int unsigned hdr_cnt;
  logic [7:0]  hdr [HDR_LEN];
  logic [31:0] skip_left;
  logic        rle;
  int unsigned bpp;
  int unsigned pkt_left;
  logic        pkt_run;
  int unsigned byte_idx;
  logic [31:0] accum;
  logic [31:0] pix_left;

  dec_word_t   expected_words [$];
  dec_word_t   seen;
  dec_word_t   want;

  function automatic string show(dec_word_t w);
    return $sformatf("kind %0d err %0d %0dx%0d bits %0d px %h %h pair %b last %b done %b",
                     w.kind, w.err, w.width, w.height, w.bits, w.first, w.second,
                     w.pair, w.last, w.done);
  endfunction

  function automatic void enter_data();
    phase    = rle ? PH_PACKET : PH_PIXEL;
    byte_idx = 0;
    accum    = '0;
  endfunction

  // n copies of one pixel, packed two to a word
  function automatic void emit_pixels(logic [31:0] px, logic [31:0] n);
    dec_word_t w;
    while (n != 0) begin
      w        = '0;
      w.pair   = (n >= 2);
      n        = n - (w.pair ? 2 : 1);
      pix_left = pix_left - (w.pair ? 2 : 1);
      w.kind   = KIND_PIXEL;
      w.err    = ERR_NONE;
      w.first  = px;
      w.second = w.pair ? px : '0;
      w.last   = (n == 0);
      w.done   = (pix_left == 0);
      expected_words.push_back(w);
    end
  endfunction

  // advance the mirror by one accepted file byte
  function automatic void decode_byte(logic [7:0] b, logic fs);
    dec_word_t   w;
    logic [7:0]  typ;
    logic [7:0]  dep;
    logic [31:0] px;
    logic [31:0] n;
    if (fs) begin
      hdr[0]  = b;
      hdr_cnt = 1;
      phase   = PH_HEADER;
      return;
    end
    case (phase)
      PH_HEADER: begin
        if (hdr_cnt >= HDR_LEN) begin
          phase = PH_IDLE;
          return;
        end
        hdr[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt < HDR_LEN) return;
        typ = hdr[2];
        dep = hdr[16];
        w   = '0;
        // type is checked ahead of depth
        if (typ != TYPE_RAW && typ != TYPE_RLE) w.err = ERR_TYPE;
        else if (dep != DEPTH_24 && dep != DEPTH_32) w.err = ERR_DEPTH;
        else w.err = ERR_NONE;
        w.kind   = (w.err == ERR_NONE) ? KIND_HDR_OK : KIND_HDR_BAD;
        w.width  = {hdr[13], hdr[12]};
        w.height = {hdr[15], hdr[14]};
        w.bits   = dep[5:0];
        w.last   = 1'b1;
        expected_words.push_back(w);
        if (w.err != ERR_NONE) begin
          phase = PH_IDLE;
          return;
        end
        rle       = (typ == TYPE_RLE);
        bpp       = dep >> 3;
        pix_left  = 32'(w.width) * 32'(w.height);
        skip_left = 32'(hdr[0]) + 32'({hdr[6], hdr[5]}) * 32'(hdr[7] >> 3);
        if (pix_left == 0) phase = PH_IDLE;
        else if (skip_left != 0) phase = PH_SKIP;
        else enter_data();
      end
      PH_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) enter_data();
      end
      PH_PACKET: begin
        pkt_run  = b[7];
        pkt_left = 32'(b[6:0]) + 1;
        phase    = PH_PIXEL;
        byte_idx = 0;
        accum    = '0;
      end
      PH_PIXEL: begin
        accum = accum | (32'(b) << ((byte_idx % 4) * 8));
        if (byte_idx + 1 < bpp) begin
          byte_idx++;
          return;
        end
        px       = accum;
        byte_idx = 0;
        accum    = '0;
        if (rle && pkt_run) begin
          // run is cut at the end of the image
          n = (pkt_left < pix_left) ? pkt_left : pix_left;
          emit_pixels(px, n);
          pkt_left = 0;
        end else begin
          emit_pixels(px, 1);
          if (rle && pkt_left > 0) pkt_left--;
        end
        if (pix_left == 0) phase = PH_IDLE;
        else if (rle && pkt_left == 0) phase = PH_PACKET;
      end
      default: ;
    endcase
  endfunction

  // compare popped words first, then predict from the accepted byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase     = PH_IDLE;
      hdr_cnt   = 0;
      foreach (hdr[i]) hdr[i] = '0;
      skip_left = '0;
      rle       = 1'b0;
      bpp       = 0;
      pkt_left  = 0;
      pkt_run   = 1'b0;
      byte_idx  = 0;
      accum     = '0;
      pix_left  = '0;
      expected_words.delete();
      fail_count_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        seen = {result_kind_i, error_code_i, image_width_i, image_height_i, pixel_bits_i,
                pixel_first_i, pixel_second_i, second_valid_i, run_last_i, image_done_i};
        if (expected_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("%0t: unexpected word: %s", $time, show(seen));
        end else begin
          want = expected_words.pop_front();
          if (seen !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: word mismatch\n  expected %s\n  actual   %s",
                       $time, show(want), show(seen));
          end
        end
      end
      if (push_i && !full_i) decode_byte(data_byte_i, frame_start_i);
    end
    pending_o = expected_words.size();
  end

endmodule

/* verif/tga_rle_image_decoder_tb.sv */
`timescale 1ns / 100ps

module tga_rle_image_decoder_tb;
  import tga_pkg::*;

  localparam int unsigned RAND_BYTES  = 20;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned TAIL_CYCLES = 20;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  data_byte   = '0;
  logic        frame_start = 1'b0;
  logic        pop         = 1'b0;
  logic        empty;
  logic [1:0]  result_kind;
  logic [1:0]  error_code;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [5:0]  pixel_bits;
  logic [31:0] pixel_first;
  logic [31:0] pixel_second;
  logic        second_valid;
  logic        run_last;
  logic        image_done;

  int fail_count;
  int pending;
  int burst_left = 0;
  int trunc_left = -1;
  int sent_bytes = 0;
  int cycles     = 0;
  bit hold_req   = 1'b0;

  tga_rle_image_decoder u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte),
    .frame_start_i  (frame_start),
    .pop            (pop),
    .empty          (empty),
    .result_kind_o  (result_kind),
    .error_code_o   (error_code),
    .image_width_o  (image_width),
    .image_height_o (image_height),
    .pixel_bits_o   (pixel_bits),
    .pixel_first_o  (pixel_first),
    .pixel_second_o (pixel_second),
    .second_valid_o (second_valid),
    .run_last_o     (run_last),
    .image_done_o   (image_done)
  );

  tga_rle_image_decoder_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push_i         (push),
    .full_i         (full),
    .data_byte_i    (data_byte),
    .frame_start_i  (frame_start),
    .pop_i          (pop),
    .empty_i        (empty),
    .result_kind_i  (result_kind),
    .error_code_i   (error_code),
    .image_width_i  (image_width),
    .image_height_i (image_height),
    .pixel_bits_i   (pixel_bits),
    .pixel_first_i  (pixel_first),
    .pixel_second_i (pixel_second),
    .second_valid_i (second_valid),
    .run_last_i     (run_last),
    .image_done_i   (image_done),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // pixel byte, biased towards all zeros and all ones
  function automatic logic [7:0] px_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one byte in bursts with random gaps; a truncated file drops the rest
  task automatic send_byte(input logic [7:0] b, input logic fs);
    if (trunc_left == 0) return;
    if (trunc_left > 0) trunc_left--;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push        <= 1'b1;
    data_byte   <= b;
    frame_start <= fs;
    do @(posedge clk); while (full);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic send_fill(input int unsigned n);
    for (int unsigned i = 0; i < n && trunc_left != 0; i++) send_byte(px_byte(), 1'b0);
  endtask

  task automatic send_pixel(input int unsigned nbytes);
    repeat (nbytes) send_byte(px_byte(), 1'b0);
  endtask

  task automatic send_header(input logic [7:0] id_len, input logic [7:0] typ,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] dep, input logic [15:0] cmap_len,
                             input logic [7:0] cmap_bits);
    logic [7:0] hb [HDR_LEN];
    foreach (hb[i]) hb[i] = 8'($urandom);
    hb[0]            = id_len;
    hb[2]            = typ;
    {hb[6], hb[5]}   = cmap_len;
    hb[7]            = cmap_bits;
    {hb[13], hb[12]} = w;
    {hb[15], hb[14]} = h;
    hb[16]           = dep;
    foreach (hb[i]) send_byte(hb[i], i == 0);
  endtask

  // pixel data: raw, or random run and literal packets
  task automatic send_pixels(input int unsigned nbytes, input bit rle, input int unsigned npix);
    int unsigned left;
    int unsigned cnt;
    bit          run;
    left = npix;
    while (left > 0 && trunc_left != 0) begin
      if (!rle) begin
        send_pixel(nbytes);
        left--;
      end else begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
        run = $urandom_range(0, 1);
        send_byte({run, 7'(cnt - 1)}, 1'b0);
        if (run) begin
          send_pixel(nbytes);
          left = (cnt >= left) ? 0 : left - cnt;
        end else begin
          for (int unsigned i = 0; i < cnt && left > 0; i++) begin
            send_pixel(nbytes);
            left--;
          end
        end
      end
    end
  endtask

  task automatic send_file(input logic [7:0] typ, input logic [7:0] dep,
                           input logic [15:0] w, input logic [15:0] h,
                           input logic [7:0] id_len, input logic [15:0] cmap_len,
                           input logic [7:0] cmap_bits);
    bit          ok;
    int unsigned npix;
    ok   = (typ == TYPE_RAW || typ == TYPE_RLE) && (dep == DEPTH_24 || dep == DEPTH_32);
    npix = 32'(w) * 32'(h);
    send_header(id_len, typ, w, h, dep, cmap_len, cmap_bits);
    if (ok && npix != 0) begin
      send_fill(32'(id_len) + 32'(cmap_len) * 32'(cmap_bits >> 3));
      send_pixels(dep >> 3, typ == TYPE_RLE, npix);
    end
  endtask

  // mostly small well-formed files, some broken, cut short or preceded by stray words
  task automatic rand_file();
    int unsigned pick;
    logic [7:0]  typ;
    logic [7:0]  dep;
    logic [7:0]  cmap_bits;
    logic [15:0] w;
    logic [15:0] h;
    pick = $urandom_range(0, 15);
    typ  = $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW;
    dep  = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
    w    = $urandom_range(1, 6);
    h    = $urandom_range(1, 5);
    case ($urandom_range(0, 5))
      0: cmap_bits = 8'd0;
      1: cmap_bits = 8'd8;
      2: cmap_bits = 8'd15;
      3: cmap_bits = 8'd16;
      4: cmap_bits = 8'd24;
      default: cmap_bits = 8'd32;
    endcase
    case (pick)
      0: typ = 8'($urandom);
      1: dep = 8'($urandom);
      2: trunc_left = $urandom_range(1, 40);
      3: begin
        w          = 16'($urandom);
        h          = 16'($urandom);
        trunc_left = $urandom_range(18, 60);
      end
      4: if ($urandom_range(0, 1)) w = '0; else h = '0;
      5: send_fill($urandom_range(1, 3));
      default: ;
    endcase
    send_file(typ, dep, w, h, $urandom_range(0, 3), $urandom_range(0, 2), cmap_bits);
    trunc_left = -1;
  endtask

  // reader: own stall pattern, plus a long hold-off on request
  initial begin
    int         hold_left;
    int         mode;
    logic [7:0] mask;
    hold_left = 0;
    mode      = 0;
    mask      = 8'hA5;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) begin
          mode = $urandom_range(0, 3);
          mask = 8'($urandom);
        end
        case (mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 3) != 0);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: begin
            pop  <= mask[0];
            mask  = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // stray words before any header are dropped
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // rejected headers: bad type and depth together, bad depth
    send_file(8'hFF, 8'd16, 16'h0000, 16'hFFFF, 8'd0, 16'd0, 8'd0);
    send_file(TYPE_RLE, 8'hFF, 16'd3, 16'd3, 8'd0, 16'd0, 8'd0);
    // empty image, then a word that is dropped
    send_file(TYPE_RAW, DEPTH_24, 16'd0, 16'd5, 8'd0, 16'd0, 8'd0);
    send_byte(8'h5A, 1'b0);
    // raw 24-bit with id string and colour map to skip
    send_file(TYPE_RAW, DEPTH_24, 16'd2, 16'd1, 8'd2, 16'd1, 8'd24);
    // raw 32-bit, then words after the image is complete
    send_file(TYPE_RAW, DEPTH_32, 16'd1, 16'd1, 8'd0, 16'd0, 8'd0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    // rle 32-bit: literal packet of two, then a run cut at the image end
    send_header(8'd0, TYPE_RLE, 16'd3, 16'd1, DEPTH_32, 16'd0, 8'd0);
    send_byte(8'h01, 1'b0);
    send_pixel(4);
    send_pixel(4);
    send_byte(8'hFF, 1'b0);
    send_pixel(4);
    // rle 24-bit: odd run of three, then a full 128-pixel run
    send_header(8'd0, TYPE_RLE, 16'd131, 16'd1, DEPTH_24, 16'd0, 8'd0);
    send_byte(8'h82, 1'b0);
    send_pixel(3);
    send_byte(8'hFF, 1'b0);
    send_pixel(3);
    // new frame start in the header, in the skip and in the pixel data
    trunc_left = 7;
    send_file(TYPE_RAW, DEPTH_24, 16'd4, 16'd4, 8'd0, 16'd0, 8'd0);
    trunc_left = 21;
    send_file(TYPE_RLE, DEPTH_32, 16'd2, 16'd2, 8'd200, 16'd0, 8'd0);
    trunc_left = 24;
    send_file(TYPE_RLE, DEPTH_32, 16'hFFFF, 16'hFFFF, 8'd0, 16'd0, 8'd0);
    trunc_left = -1;
    drain();

    // reader held off while a raw image streams in
    hold_req = 1'b1;
    send_file(TYPE_RAW, DEPTH_24, 16'd4, 16'd2, 8'd0, 16'd0, 8'd0);
    drain();

    sent_bytes = 0;
    while (sent_bytes < RAND_BYTES) rand_file();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
